// File: rtl/cascaded_biquad_equalizer_top_macros.svh
// assertion macros shared by the cascaded biquad equalizer rtl
// no dependencies; included by modules that carry assertions
`ifndef CASCADED_BIQUAD_EQUALIZER_TOP_MACROS_SVH
`define CASCADED_BIQUAD_EQUALIZER_TOP_MACROS_SVH

// same-cycle implication under reset
`define CBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define CBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cbq_pkg.sv
// types, constants and helper functions for the cascaded biquad equalizer
// no dependencies; imported by cbq_core and the top level
package cbq_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int NUM_SLOTS    = 7;
    localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int SEC_CNT_W    = $clog2(MAX_SECTIONS + 1);
    localparam int COEF_DEPTH   = MAX_SECTIONS * NUM_SLOTS;
    localparam int COEF_AW      = $clog2(COEF_DEPTH);

    // coefficient slots within a section
    localparam logic [2:0] SLOT_FB  = 3'd0;
    localparam logic [2:0] SLOT_A1  = 3'd1;
    localparam logic [2:0] SLOT_A2  = 3'd2;
    localparam logic [2:0] SLOT_NSH = 3'd3;
    localparam logic [2:0] SLOT_B0  = 3'd4;
    localparam logic [2:0] SLOT_B1  = 3'd5;
    localparam logic [2:0] SLOT_B2  = 3'd6;

    // configuration register indexes
    typedef logic [1:0] t_cfg_index;
    typedef logic [6:0] t_cfg_data;
    localparam t_cfg_index CFG_SECTION_COUNT = 2'd0;
    localparam t_cfg_index CFG_INPUT_SHIFT   = 2'd1;

    localparam logic signed [15:0] SHIFT_HI16 = 16'sd63;
    localparam logic signed [15:0] SHIFT_LO16 = -16'sd63;
    localparam logic signed [6:0]  SHIFT_HI   = 7'sd63;
    localparam logic signed [6:0]  SHIFT_LO   = -7'sd63;
    localparam logic signed [6:0]  SHIFT_BAD  = -7'sd64;

    typedef struct packed {
        logic              mode;
        logic [2:0]        section_index;
        logic [2:0]        slot_index;
        logic signed [15:0] coef_value;
        logic signed [15:0] sample;
        logic              frame_end;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic              out_frame_end;
    } t_out_word;

    // microcode fields
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SHIFT_MAIN,
        ACC_SHIFT_FB,
        ACC_ADD_FB,
        ACC_NEXT
    } t_acc_op;

    typedef enum logic [1:0] {
        MUL_D0,
        MUL_D1,
        MUL_YT
    } t_mul_sel;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD,
        SUM_ADD
    } t_sum_op;

    typedef enum logic [1:0] {
        SHF_HOLD,
        SHF_NEXT,
        SHF_FB,
        SHF_COMMIT
    } t_shf_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_DONE
    } t_seq_op;

    typedef struct packed {
        logic [2:0] slot;
        logic       ld_delay;
        t_acc_op    acc_op;
        t_mul_sel   mul_sel;
        t_sum_op    sum_op;
        t_shf_op    shf_op;
        logic       wr_delay;
        t_seq_op    seq_op;
    } t_uword;

    localparam t_uword UW_NOP = '{
        slot: SLOT_FB, ld_delay: 1'b0, acc_op: ACC_HOLD, mul_sel: MUL_D0,
        sum_op: SUM_HOLD, shf_op: SHF_HOLD, wr_delay: 1'b0, seq_op: SEQ_NEXT
    };

    // top to core
    typedef struct packed {
        logic                  start;
        logic                  coef_we;
        logic [COEF_AW-1:0]    coef_addr;
        logic signed [15:0]    coef_data;
        logic signed [15:0]    sample;
        logic [SEC_CNT_W-1:0]  sec_count;
        logic signed [6:0]     in_shift;
        logic                  out_free;
    } t_core_req;

    // core to top
    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [15:0] result;
    } t_core_stat;

    function automatic logic [COEF_AW-1:0] coef_addr(input int unsigned sec,
                                                      input int unsigned slot);
        return COEF_AW'(sec * NUM_SLOTS + slot);
    endfunction

    function automatic logic signed [6:0] clamp_coef_shift(input logic signed [15:0] v);
        if (v > SHIFT_HI16) begin
            return SHIFT_HI;
        end else if (v < SHIFT_LO16) begin
            return SHIFT_LO;
        end
        return 7'(v);
    endfunction

    function automatic logic signed [6:0] clamp_in_shift(input logic signed [6:0] v);
        if (v == SHIFT_BAD) begin
            return SHIFT_LO;
        end
        return v;
    endfunction

    // positive shifts left, negative shifts arithmetic right
    function automatic logic [63:0] shift64(input logic [63:0] v, input logic signed [6:0] s);
        logic [5:0] amt;
        amt = s[6] ? 6'(-s) : 6'(s);
        if (s[6]) begin
            return 64'($signed(v) >>> amt);
        end
        return v << amt;
    endfunction

endpackage

// File: rtl/cbq_core.sv
// microcoded datapath of the cascaded biquad equalizer: coefficient memory,
// delay registers, one 16x32 multiplier, 64-bit accumulator and shifter
// depends on cbq_pkg and cascaded_biquad_equalizer_top_macros.svh
`include "cascaded_biquad_equalizer_top_macros.svh"

module cbq_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbq_pkg::t_core_req   i_req,
    output cbq_pkg::t_core_stat  o_stat
);
    import cbq_pkg::*;

    // microcode addresses
    localparam logic [3:0] ST_LD  = 4'd0;
    localparam logic [3:0] ST_C3  = 4'd1;
    localparam logic [3:0] ST_MA1 = 4'd2;
    localparam logic [3:0] ST_MA2 = 4'd3;
    localparam logic [3:0] ST_FB  = 4'd4;
    localparam logic [3:0] ST_ADD = 4'd5;
    localparam logic [3:0] ST_SHF = 4'd6;
    localparam logic [3:0] ST_YT  = 4'd7;
    localparam logic [3:0] ST_NXT = 4'd8;
    localparam logic [3:0] ST_FIN = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;

    localparam logic signed [15:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [15:0] SAT_NEG = -16'sh8000;

    function automatic t_uword ucode(input logic [3:0] step);
        t_uword w;
        w = UW_NOP;
        case (step)
            ST_LD: begin
                w.slot     = SLOT_NSH;
                w.ld_delay = 1'b1;
                w.acc_op   = ACC_SHIFT_MAIN;
            end
            ST_C3: begin
                w.slot   = SLOT_A1;
                w.shf_op = SHF_NEXT;
            end
            ST_MA1: begin
                w.slot    = SLOT_A2;
                w.mul_sel = MUL_D0;
            end
            ST_MA2: begin
                w.slot    = SLOT_FB;
                w.mul_sel = MUL_D1;
                w.sum_op  = SUM_LOAD;
            end
            ST_FB: begin
                w.slot   = SLOT_B0;
                w.sum_op = SUM_ADD;
                w.shf_op = SHF_FB;
            end
            ST_ADD: begin
                w.slot    = SLOT_B1;
                w.acc_op  = ACC_ADD_FB;
                w.mul_sel = MUL_D0;
            end
            ST_SHF: begin
                w.slot    = SLOT_B2;
                w.acc_op  = ACC_SHIFT_FB;
                w.mul_sel = MUL_D1;
                w.sum_op  = SUM_LOAD;
            end
            ST_YT: begin
                w.mul_sel  = MUL_YT;
                w.sum_op   = SUM_ADD;
                w.wr_delay = 1'b1;
            end
            ST_NXT: begin
                w.acc_op = ACC_NEXT;
                w.shf_op = SHF_COMMIT;
                w.seq_op = SEQ_LOOP;
            end
            ST_FIN: begin
                w.acc_op = ACC_SHIFT_MAIN;
            end
            ST_OUT: begin
                w.seq_op = SEQ_DONE;
            end
            default: begin
                w.seq_op = SEQ_DONE;
            end
        endcase
        return w;
    endfunction

    logic signed [15:0] r_coef_mem [COEF_DEPTH];
    logic signed [15:0] r_coef;
    logic signed [31:0] r_d0_mem [MAX_SECTIONS];
    logic signed [31:0] r_d1_mem [MAX_SECTIONS];

    logic                 r_busy,  n_busy;
    logic [3:0]           r_step,  n_step;
    logic [SEC_W-1:0]     r_sec,   n_sec;
    logic [SEC_CNT_W-1:0] r_nsec,  n_nsec;
    logic signed [6:0]    r_shift, n_shift;
    logic signed [6:0]    r_nshift, n_nshift;
    logic signed [6:0]    r_fb,    n_fb;
    logic [63:0]          r_acc,   n_acc;
    logic signed [31:0]   r_d0,    r_d1;
    logic signed [47:0]   r_prod;
    logic signed [48:0]   r_sum,   n_sum;

    t_uword              uw;
    logic [COEF_AW-1:0]  rd_addr;
    logic signed [31:0]  mul_b;
    logic signed [63:0]  sum_x, prod_x;
    logic [63:0]         sum_sr, prod_sr, shifted;
    logic signed [6:0]   shift_amt;
    logic                last_sec;
    logic                sat_ovf;
    logic                done;
    logic signed [15:0]  result;

    assign uw      = ucode(r_step);
    assign rd_addr = coef_addr(32'(r_sec), 32'(uw.slot));

    always_comb begin
        case (uw.mul_sel)
            MUL_D0:  mul_b = r_d0;
            MUL_D1:  mul_b = r_d1;
            MUL_YT:  mul_b = $signed(r_acc[31:0]);
            default: mul_b = r_d0;
        endcase
    end

    assign sum_x     = {{15{r_sum[48]}}, r_sum};
    assign prod_x    = {{16{r_prod[47]}}, r_prod};
    assign sum_sr    = 64'(sum_x >>> 15);
    assign prod_sr   = 64'(prod_x >>> 15);
    assign shift_amt = (uw.acc_op == ACC_SHIFT_FB) ? r_fb : r_shift;
    assign shifted   = shift64(r_acc, shift_amt);
    assign last_sec  = (32'(r_sec) + 1 >= 32'(r_nsec));

    // saturate to 32 bits and keep the upper half
    assign sat_ovf = !((&r_acc[63:31]) || !(|r_acc[63:31]));
    assign result  = sat_ovf ? (r_acc[63] ? SAT_NEG : SAT_POS) : $signed(r_acc[31:16]);
    assign done    = r_busy && (uw.seq_op == SEQ_DONE) && i_req.out_free;

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_sec    = r_sec;
        n_nsec   = r_nsec;
        n_shift  = r_shift;
        n_nshift = r_nshift;
        n_fb     = r_fb;
        n_acc    = r_acc;
        n_sum    = r_sum;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy  = 1'b1;
                n_step  = ST_LD;
                n_sec   = '0;
                n_nsec  = i_req.sec_count;
                n_shift = i_req.in_shift;
                n_acc   = {{32{i_req.sample[15]}}, i_req.sample, 16'h0000};
            end
        end else begin
            case (uw.acc_op)
                ACC_SHIFT_MAIN, ACC_SHIFT_FB: n_acc = shifted;
                ACC_ADD_FB:                   n_acc = r_acc + sum_sr;
                ACC_NEXT:                     n_acc = sum_sr + prod_sr;
                default:                      n_acc = r_acc;
            endcase
            case (uw.sum_op)
                SUM_LOAD: n_sum = {r_prod[47], r_prod};
                SUM_ADD:  n_sum = r_sum + {r_prod[47], r_prod};
                default:  n_sum = r_sum;
            endcase
            case (uw.shf_op)
                SHF_NEXT:   n_nshift = clamp_coef_shift(r_coef);
                SHF_FB:     n_fb     = clamp_coef_shift(r_coef);
                SHF_COMMIT: n_shift  = r_nshift;
                default:    n_shift  = r_shift;
            endcase
            case (uw.seq_op)
                SEQ_NEXT: n_step = r_step + 4'd1;
                SEQ_LOOP: begin
                    if (last_sec) begin
                        n_step = ST_FIN;
                    end else begin
                        n_step = ST_LD;
                        n_sec  = r_sec + SEC_W'(1);
                    end
                end
                SEQ_DONE: begin
                    if (i_req.out_free) begin
                        n_busy = 1'b0;
                    end
                end
                default: n_step = r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_LD;
            r_sec  <= '0;
            r_nsec <= SEC_CNT_W'(1);
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_d0_mem[i] <= '0;
                r_d1_mem[i] <= '0;
            end
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_sec  <= n_sec;
            r_nsec <= n_nsec;
            if (r_busy && uw.wr_delay) begin
                r_d0_mem[r_sec] <= r_d1;
                r_d1_mem[r_sec] <= $signed(r_acc[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_nshift <= n_nshift;
        r_fb     <= n_fb;
        r_acc    <= n_acc;
        r_sum    <= n_sum;
        r_prod   <= r_coef * mul_b;
        if (uw.ld_delay) begin
            r_d0 <= r_d0_mem[r_sec];
            r_d1 <= r_d1_mem[r_sec];
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_req.coef_we) begin
            r_coef_mem[i_req.coef_addr] <= i_req.coef_data;
        end
        r_coef <= r_coef_mem[rd_addr];
    end

    assign o_stat.busy   = r_busy;
    assign o_stat.done   = done;
    assign o_stat.result = result;

    `CBQ_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy, "start while busy")
    `CBQ_ASSERT_IMP(a_sec_range, i_clk, i_rst_n, r_busy, 32'(r_sec) < 32'(r_nsec),
        "section index beyond section count")
    `CBQ_ASSERT_IMP(a_done_step, i_clk, i_rst_n, done, r_step == ST_OUT,
        "result outside emit step")
    `CBQ_ASSERT_NXT(a_loop_back, i_clk, i_rst_n, r_busy && r_step == ST_NXT && !last_sec,
        r_step == ST_LD && r_busy, "section loop did not return")

endmodule

// File: rtl/cascaded_biquad_equalizer_top.sv
// top level of the cascaded biquad equalizer: handshakes, configuration
// registers and the output register around the microcoded core
// depends on cbq_pkg, cbq_core and cascaded_biquad_equalizer_top_macros.svh

// A sample word (mode 0) runs through section_count biquad sections on one
// microcoded datapath with a single 16x32 multiplier: the sequencer runs the
// steps of every section in use, then a final shift step and an emit step that
// loads the result into the output register, after which the next word can be
// taken. While the output register holds a stalled word, the sequencer waits in
// its last step and the input stall lasts that much longer. A coefficient word
// (mode 1) with an in-range slot index is written to the coefficient memory in
// its accept cycle and gives no result. The input stalls while a sample is in
// the sequencer; a finished result waits in the output register while the next
// word is taken. Coefficients must be written before a sample uses them; the
// section delays clear on reset. Configuration writes are always accepted; a
// sample uses the register values in force when it is accepted.
`include "cascaded_biquad_equalizer_top_macros.svh"

module cascaded_biquad_equalizer_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cbq_pkg::t_in_word    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cbq_pkg::t_out_word   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  cbq_pkg::t_cfg_index  i_cfg_index,
    input  cbq_pkg::t_cfg_data   i_cfg_data
);
    import cbq_pkg::*;

    logic [3:0]        r_section_count;
    logic signed [6:0] r_input_shift;
    logic              r_frame;
    logic              r_out_valid;
    t_out_word         r_out;

    t_core_req            req;
    t_core_stat           stat;
    logic                 in_acc;
    logic                 cfg_acc;
    logic [SEC_CNT_W-1:0] sec_count;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = stat.busy;

    always_comb begin
        if (r_section_count == '0) begin
            sec_count = SEC_CNT_W'(1);
        end else if (32'(r_section_count) > MAX_SECTIONS) begin
            sec_count = SEC_CNT_W'(MAX_SECTIONS);
        end else begin
            sec_count = SEC_CNT_W'(r_section_count);
        end
    end

    always_comb begin
        req.start     = in_acc && !i_in_data.mode;
        req.coef_we   = in_acc && i_in_data.mode
                        && (32'(i_in_data.slot_index) < NUM_SLOTS)
                        && (32'(i_in_data.section_index) < MAX_SECTIONS);
        req.coef_addr = coef_addr(32'(i_in_data.section_index), 32'(i_in_data.slot_index));
        req.coef_data = i_in_data.coef_value;
        req.sample    = i_in_data.sample;
        req.sec_count = sec_count;
        req.in_shift  = clamp_in_shift(r_input_shift);
        req.out_free  = !r_out_valid || !i_out_stall;
    end

    cbq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_stat  (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= 4'd1;
            r_input_shift   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_SECTION_COUNT: r_section_count <= i_cfg_data[3:0];
                    CFG_INPUT_SHIFT:   r_input_shift   <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (stat.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.start) begin
            r_frame <= i_in_data.frame_end;
        end
        if (stat.done) begin
            r_out.out_sample    <= stat.result;
            r_out.out_frame_end <= r_frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CBQ_ASSERT_IMP(a_done_room, i_clk, i_rst_n, stat.done, !r_out_valid || !i_out_stall,
        "result overwrote a waiting word")
    `CBQ_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, stat.done, r_out_valid,
        "result not presented")
    `CBQ_ASSERT_NXT(a_sample_busy, i_clk, i_rst_n, in_acc && !i_in_data.mode, stat.busy,
        "accepted sample did not start the sequencer")

endmodule

// File: test/tb.sv
// self-checking testbench for cascaded_biquad_equalizer_top: sample and coefficient words,
// register settings and random idling on both channels, each output word checked against
// a local cascade predictor; depends on cbq_pkg and the rtl top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbq_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int PAUSE_CYCLES  = 100;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 180;
    localparam int STREAM_WORDS  = 200;
    localparam int PRINT_LIMIT   = 50;
    localparam logic [2:0] SLOT_NONE = 3'd7;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_SECTION_COUNT;
    t_cfg_data  i_cfg_data = '0;

    cascaded_biquad_equalizer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic signed [15:0] coef_mem [MAX_SECTIONS*NUM_SLOTS];
    logic signed [31:0] delay_mem [MAX_SECTIONS*2];
    logic [3:0]         sections_reg = 4'd1;
    logic signed [6:0]  pre_shift_reg = '0;
    t_out_word          pending_outputs[$];

    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int mismatches = 0;
    int results_checked = 0;
    int samples_sent = 0;
    int coef_words_sent = 0;
    int reg_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < MAX_SECTIONS*NUM_SLOTS; i++) coef_mem[i] = '0;
        for (int i = 0; i < MAX_SECTIONS*2; i++) delay_mem[i] = '0;
    end

    function automatic int clip_shift(input int s);
        if (s > 63) return 63;
        if (s < -63) return -63;
        return s;
    endfunction

    // positive shifts left, negative shifts arithmetic right
    function automatic logic [63:0] scale_word(input logic [63:0] v, input int s);
        logic signed [63:0] sv;
        sv = v;
        if (s < 0) return sv >>> (-s);
        return v << s;
    endfunction

    function automatic void store_coef(input t_in_word w);
        if (w.slot_index < NUM_SLOTS && w.section_index < MAX_SECTIONS) begin
            coef_mem[w.section_index*NUM_SLOTS + w.slot_index] = w.coef_value;
        end
    endfunction

    // runs one sample through the cascade and advances the section delays
    function automatic t_out_word filter_sample(input t_in_word w);
        t_out_word r;
        int n, sh, base;
        logic [63:0] acc, y, last;
        logic signed [63:0] d0, d1, c_a1, c_a2, c_b0, c_b1, c_b2, yt, fb_sum, ff_sum, tail;
        n = sections_reg;
        if (n == 0) n = 1;
        if (n > MAX_SECTIONS) n = MAX_SECTIONS;
        acc = {{32{w.sample[15]}}, w.sample, 16'h0000};
        sh = clip_shift(pre_shift_reg);
        for (int k = 0; k < n; k++) begin
            base = k * NUM_SLOTS;
            d0 = delay_mem[2*k];
            d1 = delay_mem[2*k+1];
            c_a1 = coef_mem[base + SLOT_A1];
            c_a2 = coef_mem[base + SLOT_A2];
            c_b0 = coef_mem[base + SLOT_B0];
            c_b1 = coef_mem[base + SLOT_B1];
            c_b2 = coef_mem[base + SLOT_B2];
            acc = scale_word(acc, sh);
            sh = clip_shift(coef_mem[base + SLOT_NSH]);
            fb_sum = (c_a1 * d0 + c_a2 * d1) >>> 15;
            y = scale_word(acc + fb_sum, clip_shift(coef_mem[base + SLOT_FB]));
            yt = $signed(y[31:0]);
            ff_sum = (c_b0 * d0 + c_b1 * d1) >>> 15;
            tail = (c_b2 * yt) >>> 15;
            acc = ff_sum + tail;
            delay_mem[2*k] = d1[31:0];
            delay_mem[2*k+1] = yt[31:0];
        end
        last = scale_word(acc, sh);
        if (((last + 64'h0000_0000_8000_0000) >> 32) != 0) begin
            last = last[63] ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        end
        r.out_sample = last[31:16];
        r.out_frame_end = w.frame_end;
        return r;
    endfunction

    function automatic t_in_word make_sample(input int value, input logic fe);
        t_in_word w;
        w.mode = 1'b0;
        w.section_index = 3'($urandom);
        w.slot_index = 3'($urandom);
        w.coef_value = 16'($urandom);
        w.sample = 16'(value);
        w.frame_end = fe;
        return w;
    endfunction

    function automatic t_in_word make_coef(input int sec, input logic [2:0] slot,
                                           input int value);
        t_in_word w;
        w.mode = 1'b1;
        w.section_index = 3'(sec);
        w.slot_index = slot;
        w.coef_value = 16'(value);
        w.sample = 16'($urandom);
        w.frame_end = 1'($urandom);
        return w;
    endfunction

    function automatic int random_coef(input logic [2:0] slot);
        if ($urandom_range(3, 0) == 0) return int'($signed(16'($urandom)));
        if (slot == SLOT_FB || slot == SLOT_NSH) return int'($urandom_range(6, 0)) - 3;
        return int'($urandom_range(24000, 0)) - 12000;
    endfunction

    function automatic t_in_word random_word();
        logic [2:0] slot;
        if ($urandom_range(99, 0) < 15) begin
            slot = 3'($urandom);
            return make_coef($urandom_range(7, 0), slot, random_coef(slot));
        end
        if ($urandom_range(9, 0) < 7) return make_sample(int'($urandom), 1'($urandom));
        return make_sample(int'($urandom_range(600, 0)) - 300, 1'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_checked, what, got, want);
        end
    endtask

    // one word into the block, predicted at acceptance
    task automatic send_word(input t_in_word w);
        if (in_gap_pct != 0 && $urandom_range(99, 0) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (w.mode == 1'b0) begin
            pending_outputs.push_back(filter_sample(w));
            samples_sent++;
        end else begin
            store_coef(w);
            coef_words_sent++;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
        repeat (PAUSE_CYCLES) @(posedge i_clk);
    endtask

    // writes both registers back to back, block idle
    task automatic set_config(input t_cfg_data count_data, input t_cfg_data shift_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SECTION_COUNT;
        i_cfg_data <= count_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sections_reg = count_data[3:0];
        i_cfg_index <= CFG_INPUT_SHIFT;
        i_cfg_data <= shift_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pre_shift_reg = shift_data;
        i_cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    task automatic test_coef_setup();
        set_config(7'd1, 7'd0);
        for (int sec = 0; sec < MAX_SECTIONS; sec++) begin
            for (int slot = 0; slot < NUM_SLOTS; slot++) begin
                send_word(make_coef(sec, 3'(slot), (3'(slot) == SLOT_B2) ? 32767 : 0));
            end
        end
    endtask

    task automatic test_sample_extremes();
        send_word(make_sample(32767, 1'b0));
        send_word(make_sample(-32768, 1'b1));
        send_word(make_sample(0, 1'b0));
        send_word(make_sample(-1, 1'b1));
        send_word(make_sample(1, 1'b0));
        drain_results();
        set_config(7'd8, 7'd0);
        send_word(make_sample(-32768, 1'b1));
        send_word(make_sample(32767, 1'b0));
    endtask

    task automatic test_register_extremes();
        drain_results();
        set_config(7'd0, 7'd63);
        send_word(make_sample(1, 1'b1));
        send_word(make_sample(-1, 1'b0));
        drain_results();
        set_config(7'h7F, t_cfg_data'(-64));
        send_word(make_sample(32767, 1'b0));
        send_word(make_sample(-32768, 1'b1));
        drain_results();
        set_config(7'd9, t_cfg_data'(-63));
        send_word(make_sample(-32768, 1'b0));
    endtask

    task automatic test_shift_clamping();
        drain_results();
        set_config(7'd2, 7'd0);
        send_word(make_coef(0, SLOT_FB, 32767));
        send_word(make_coef(0, SLOT_NSH, -32768));
        send_word(make_sample(12345, 1'b0));
        send_word(make_coef(1, SLOT_FB, -64));
        send_word(make_coef(1, SLOT_NSH, 64));
        send_word(make_sample(-20000, 1'b1));
        send_word(make_coef(0, SLOT_FB, 0));
        send_word(make_coef(1, SLOT_FB, 0));
        send_word(make_coef(1, SLOT_NSH, 0));
        // next shift of 4 pushes a full scale value past 32 bits
        send_word(make_coef(0, SLOT_NSH, 4));
        drain_results();
        set_config(7'd1, 7'd0);
        send_word(make_sample(32767, 1'b0));
        send_word(make_sample(-32768, 1'b1));
        send_word(make_coef(0, SLOT_NSH, 0));
    endtask

    task automatic test_bad_slot();
        send_word(make_coef(0, SLOT_NONE, 16'h1234));
        send_word(make_coef(7, SLOT_NONE, -1));
        send_word(make_sample(4321, 1'b1));
    endtask

    task automatic test_random_phases();
        int cnt, shf;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin cnt = 8; shf = 0; end
                1: begin cnt = 1; shf = -64; end
                2: begin cnt = 15; shf = 63; end
                3: begin cnt = 0; shf = -63; end
                default: begin
                    cnt = ($urandom_range(9, 0) < 6) ? $urandom_range(8, 1) : $urandom_range(15, 0);
                    shf = ($urandom_range(1, 0) == 0) ? int'($urandom_range(8, 0)) - 4
                                                      : int'($urandom_range(127, 0));
                end
            endcase
            set_config({3'($urandom), 4'(cnt)}, t_cfg_data'(shf));
            in_gap_pct = (phase % 3 == 2) ? 0 : $urandom_range(60, 5);
            out_stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(60, 5);
            for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word());
        end
    endtask

    task automatic test_streaming();
        drain_results();
        set_config({3'($urandom), 4'($urandom_range(8, 1))},
                   t_cfg_data'(int'($urandom_range(4, 0)) - 2));
        in_gap_pct = 0;
        out_stall_pct = 0;
        for (int i = 0; i < STREAM_WORDS; i++) send_word(random_word());
    endtask

    // output side stall bursts
    always @(posedge i_clk) begin : out_stall_gen
        static int stall_left = 0;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct) begin
            stall_left = $urandom_range(14, 0);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_outputs.size() == 0) begin
                report_mismatch("word with none expected", o_out_data.out_sample, 0);
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_data.out_sample !== want.out_sample) begin
                    report_mismatch("out_sample", o_out_data.out_sample, want.out_sample);
                end
                if (o_out_data.out_frame_end !== want.out_frame_end) begin
                    report_mismatch("out_frame_end", o_out_data.out_frame_end,
                                    want.out_frame_end);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[cascaded_biquad_equalizer_top] ERROR");
        $finish;
    end

    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_gap_pct = 30;
        out_stall_pct = 30;
        test_coef_setup();
        test_sample_extremes();
        test_register_extremes();
        test_shift_clamping();
        test_bad_slot();
        test_random_phases();
        test_streaming();
        drain_results();
        $display("run covered %0d samples, %0d coefficient words and %0d register writes",
                 samples_sent, coef_words_sent, reg_writes);
        $display("%0d output words checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("[cascaded_biquad_equalizer_top] OK");
        end else begin
            $display("[cascaded_biquad_equalizer_top] ERROR");
        end
        $finish;
    end

endmodule
